/* src/sha1_pkg.sv */
// package with item types, sequencer states and constants of the sha-1 digest block
`timescale 1ns / 1ps

package sha1_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD_ONE,
    S_PAD_ZERO,
    S_PAD_LEN,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_e;

  localparam int unsigned DigestWords = 5;
  localparam int unsigned BlockWords  = 16;
  localparam logic [6:0]  LastRound   = 7'd79;
  localparam logic [5:0]  LastFill    = 6'd63;
  localparam logic [5:0]  LenFill     = 6'd56;
  localparam logic [2:0]  LastIndex   = 3'd4;

  localparam logic [31:0] InitValue [DigestWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte  = 8'b10000000;
  localparam logic [7:0] ZeroByte = 8'h00;

endpackage

/* src/sha1_message_digest.sv */
// sha-1 digest over a byte stream with one shared round unit and a small sequencer
`timescale 1ns / 1ps

// channel   dir  handshake                payload
// in        in   in_valid_i / in_stall_o  in_data_i  (data_byte, byte_present, end_of_message)
// out       out  out_valid_o / out_stall_i out_data_o (digest_word, word_index, last_word)
//
// a byte item is taken while the sequencer is idle; the item that fills a block adds 80 rounds
// through the single round unit, then one chaining add
// an end item adds the padding bytes, one or two compressions and the
// five digest words on the output; in_stall_o is high whenever the sequencer is not idle
// asynchronous active-low reset loads the initial values; out_stall_i holds a word

module sha1_message_digest (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sha1_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sha1_pkg::out_item_t out_data_o
);

  sha1_pkg::state_e state_q, state_d, ret_q, ret_d;

  logic [31:0] chain_q [sha1_pkg::DigestWords];
  logic [31:0] chain_d [sha1_pkg::DigestWords];
  logic [31:0] work_q  [sha1_pkg::DigestWords];
  logic [31:0] work_d  [sha1_pkg::DigestWords];
  logic [31:0] line_q  [sha1_pkg::BlockWords];
  logic [31:0] line_d  [sha1_pkg::BlockWords];
  logic [23:0] acc_q, acc_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] count_q, count_d;
  logic [6:0]  round_q, round_d;
  logic [2:0]  idx_q, idx_d;

  logic        push;
  logic [7:0]  push_byte;
  logic [7:0]  len_byte;
  logic [5:0]  fill_next;
  logic [31:0] f_val, k_val, tmp, sched_new;
  logic        in_acc, out_acc;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_acc   = out_valid_o && !out_stall_i;
  assign fill_next = fill_q + 6'd1;
  assign len_byte  = 8'(count_q >> {~fill_q[2:0], 3'b000});

  // round unit
  always_comb begin
    if (round_q inside {[7'd0 : 7'd19]}) begin
      f_val = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
      k_val = sha1_pkg::K0;
    end else if (round_q inside {[7'd20 : 7'd39]}) begin
      f_val = work_q[1] ^ work_q[2] ^ work_q[3];
      k_val = sha1_pkg::K1;
    end else if (round_q inside {[7'd40 : 7'd59]}) begin
      f_val = (work_q[1] & work_q[2]) | (work_q[1] & work_q[3]) | (work_q[2] & work_q[3]);
      k_val = sha1_pkg::K2;
    end else begin
      f_val = work_q[1] ^ work_q[2] ^ work_q[3];
      k_val = sha1_pkg::K3;
    end
    tmp = {work_q[0][26:0], work_q[0][31:27]} + f_val + work_q[4] + line_q[0] + k_val;
    sched_new = line_q[13] ^ line_q[8] ^ line_q[2] ^ line_q[0];
    sched_new = {sched_new[30:0], sched_new[31]};
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    chain_d = chain_q;
    work_d  = work_q;
    line_d  = line_q;
    acc_d   = acc_q;
    fill_d  = fill_q;
    count_d = count_q;
    round_d = round_q;
    idx_d   = idx_q;
    push      = 1'b0;
    push_byte = sha1_pkg::ZeroByte;

    case (state_q)
      sha1_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.byte_present) begin
            push      = 1'b1;
            push_byte = in_data_i.data_byte;
            count_d   = count_q + 64'd8;
          end
          if (push && fill_q == sha1_pkg::LastFill) begin
            state_d = sha1_pkg::S_ROUND;
            ret_d   = in_data_i.end_of_message ? sha1_pkg::S_PAD_ONE : sha1_pkg::S_IDLE;
          end else if (in_data_i.end_of_message) begin
            state_d = sha1_pkg::S_PAD_ONE;
          end
        end
      end
      sha1_pkg::S_PAD_ONE, sha1_pkg::S_PAD_ZERO: begin
        push      = 1'b1;
        push_byte = (state_q == sha1_pkg::S_PAD_ONE) ? sha1_pkg::PadByte : sha1_pkg::ZeroByte;
        if (fill_q == sha1_pkg::LastFill) begin
          state_d = sha1_pkg::S_ROUND;
          ret_d   = sha1_pkg::S_PAD_ZERO;
        end else if (fill_next == sha1_pkg::LenFill) begin
          state_d = sha1_pkg::S_PAD_LEN;
        end else begin
          state_d = sha1_pkg::S_PAD_ZERO;
        end
      end
      sha1_pkg::S_PAD_LEN: begin
        push      = 1'b1;
        push_byte = len_byte;
        if (fill_q == sha1_pkg::LastFill) begin
          state_d = sha1_pkg::S_ROUND;
          ret_d   = sha1_pkg::S_OUT;
        end
      end
      sha1_pkg::S_ROUND: begin
        work_d[4] = work_q[3];
        work_d[3] = work_q[2];
        work_d[2] = {work_q[1][1:0], work_q[1][31:2]};
        work_d[1] = work_q[0];
        work_d[0] = tmp;
        for (int i = 0; i < sha1_pkg::BlockWords - 1; i++) begin
          line_d[i] = line_q[i+1];
        end
        line_d[sha1_pkg::BlockWords-1] = sched_new;
        round_d = round_q + 7'd1;
        if (round_q == sha1_pkg::LastRound) begin
          round_d = '0;
          state_d = sha1_pkg::S_ADD;
        end
      end
      sha1_pkg::S_ADD: begin
        for (int i = 0; i < sha1_pkg::DigestWords; i++) begin
          chain_d[i] = chain_q[i] + work_q[i];
        end
        state_d = ret_q;
        idx_d   = '0;
      end
      sha1_pkg::S_OUT: begin
        if (out_acc) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == sha1_pkg::LastIndex) begin
            idx_d   = '0;
            chain_d = sha1_pkg::InitValue;
            count_d = '0;
            fill_d  = '0;
            state_d = sha1_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = sha1_pkg::S_IDLE;
      end
    endcase

    // byte packing into the schedule line
    if (push) begin
      fill_d = fill_next;
      if (fill_q[1:0] == 2'd3) begin
        for (int i = 0; i < sha1_pkg::BlockWords - 1; i++) begin
          line_d[i] = line_q[i+1];
        end
        line_d[sha1_pkg::BlockWords-1] = {acc_q, push_byte};
      end else begin
        acc_d = {acc_q[15:0], push_byte};
      end
      if (fill_q == sha1_pkg::LastFill) begin
        work_d = chain_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha1_pkg::S_IDLE;
      ret_q   <= sha1_pkg::S_IDLE;
      chain_q <= sha1_pkg::InitValue;
      work_q  <= '{default: '0};
      fill_q  <= '0;
      count_q <= '0;
      round_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      chain_q <= chain_d;
      work_q  <= work_d;
      fill_q  <= fill_d;
      count_q <= count_d;
      round_q <= round_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q <= line_d;
    acc_q  <= acc_d;
  end

  assign in_stall_o             = (state_q != sha1_pkg::S_IDLE);
  assign out_valid_o            = (state_q == sha1_pkg::S_OUT);
  assign out_data_o.digest_word = chain_q[idx_q];
  assign out_data_o.word_index  = idx_q;
  assign out_data_o.last_word   = (idx_q == sha1_pkg::LastIndex);

endmodule

/* src/sha1_md_checker.sv */
// port-level checker for the sha-1 digest block and its bind
`timescale 1ns / 1ps

module sha1_md_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sha1_pkg::out_item_t out_data_o
);

  // stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled digest word changed");

  // no item taken while the digest goes out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input ready during digest output");

  // words follow in order without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_word |=>
      out_valid_o && out_data_o.word_index == $past(out_data_o.word_index) + 3'd1)
    else $error("digest word sequence broken");

  // a digest starts at word zero after input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> out_data_o.word_index == 3'd0)
    else $error("digest did not start at word zero");

  // last flag only on the fifth word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.last_word == (out_data_o.word_index == sha1_pkg::LastIndex))
    else $error("last word flag mismatch");

endmodule

bind sha1_message_digest sha1_md_checker u_sha1_md_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* tb/sha1_message_digest_test.sv */
// self-checking testbench for the byte-serial sha-1 digest block
`timescale 1ns / 1ps

module sha1_message_digest_test;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  sha1_pkg::in_item_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  sha1_pkg::out_item_t out_data_o;

  sha1_message_digest dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  sha1_pkg::in_item_t  pending_items [$];
  sha1_pkg::out_item_t expected_digest_words [$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count    = 0;
  int unsigned items_queued   = 0;

  // digest state
  logic [31:0] chain_words [sha1_pkg::DigestWords];
  logic [31:0] block_words [sha1_pkg::BlockWords];
  logic [5:0]  block_fill;
  logic [63:0] message_bits;

  function automatic void reset_digest_state();
    for (int i = 0; i < sha1_pkg::DigestWords; i++) chain_words[i] = sha1_pkg::InitValue[i];
    for (int i = 0; i < sha1_pkg::BlockWords; i++) block_words[i] = '0;
    block_fill   = '0;
    message_bits = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] sched [80];
    logic [31:0] a, b, c, d, e, f, k, tmp;
    for (int t = 0; t < sha1_pkg::BlockWords; t++) sched[t] = block_words[t];
    for (int t = sha1_pkg::BlockWords; t < 80; t++) begin
      tmp = sched[t-3] ^ sched[t-8] ^ sched[t-14] ^ sched[t-16];
      sched[t] = {tmp[30:0], tmp[31]};
    end
    a = chain_words[0];
    b = chain_words[1];
    c = chain_words[2];
    d = chain_words[3];
    e = chain_words[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = sha1_pkg::K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = sha1_pkg::K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1_pkg::K3;
      end
      tmp = {a[26:0], a[31:27]} + f + e + sched[r] + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = tmp;
    end
    chain_words[0] += a;
    chain_words[1] += b;
    chain_words[2] += c;
    chain_words[3] += d;
    chain_words[4] += e;
  endfunction

  function automatic void push_byte(logic [7:0] value);
    logic [3:0] widx;
    widx = block_fill[5:2];
    if (block_fill[1:0] == 2'd0) block_words[widx] = '0;
    block_words[widx] |= {24'd0, value} << (8 * (3 - block_fill[1:0]));
    if (block_fill == sha1_pkg::LastFill) begin
      compress_block();
      block_fill = '0;
    end else begin
      block_fill = block_fill + 6'd1;
    end
  endfunction

  function automatic void absorb_item(sha1_pkg::in_item_t item);
    logic [63:0]         len;
    sha1_pkg::out_item_t word;
    if (item.byte_present) begin
      push_byte(item.data_byte);
      message_bits += 64'd8;
    end
    if (item.end_of_message) begin
      len = message_bits;
      push_byte(sha1_pkg::PadByte);
      while (block_fill != sha1_pkg::LenFill) push_byte(sha1_pkg::ZeroByte);
      for (int i = 0; i < 8; i++) push_byte(len[63 - 8 * i -: 8]);
      for (int i = 0; i < sha1_pkg::DigestWords; i++) begin
        word.digest_word = chain_words[i];
        word.word_index  = 3'(i);
        word.last_word   = (3'(i) == sha1_pkg::LastIndex);
        expected_digest_words = {expected_digest_words, word};
      end
      reset_digest_state();
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) absorb_item(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    sha1_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_digest_words.size() == 0) begin
        report_mismatch("unexpected item", out_data_o.digest_word, '0);
      end else begin
        want = expected_digest_words.pop_front();
        if (out_data_o.digest_word !== want.digest_word)
          report_mismatch("digest_word", out_data_o.digest_word, want.digest_word);
        if (out_data_o.word_index !== want.word_index)
          report_mismatch("word_index", 32'(out_data_o.word_index), 32'(want.word_index));
        if (out_data_o.last_word !== want.last_word)
          report_mismatch("last_word", 32'(out_data_o.last_word), 32'(want.last_word));
      end
    end
  end

  function automatic sha1_pkg::in_item_t make_item(logic [7:0] data, logic present,
                                                   logic last);
    sha1_pkg::in_item_t item;
    item.data_byte      = data;
    item.byte_present   = present;
    item.end_of_message = last;
    return item;
  endfunction

  task automatic queue_item(sha1_pkg::in_item_t item);
    pending_items = {pending_items, item};
    items_queued++;
  endtask

  // n message bytes with idle items mixed in; the end item carries the last byte or follows it
  task automatic queue_message(int unsigned n);
    bit end_carries_byte;
    end_carries_byte = (n > 0) && $urandom_range(1);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(7) == 0) queue_item(make_item(8'($urandom), 1'b0, 1'b0));
      if (end_carries_byte && i == n - 1)
        queue_item(make_item(8'($urandom), 1'b1, 1'b1));
      else
        queue_item(make_item(8'($urandom), 1'b1, 1'b0));
    end
    if (!end_carries_byte) queue_item(make_item(8'($urandom), 1'b0, 1'b1));
  endtask

  task automatic wait_for_drain();
    while (pending_items.size() > 0 || in_valid_i || expected_digest_words.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    int unsigned idle_plan  [4] = '{0, 82, 0, 26};
    int unsigned stall_plan [4] = '{0, 0, 82, 26};
    int unsigned edge_len   [4] = '{55, 64, 58, 0};
    int unsigned phase_start;
    reset_digest_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed items
    queue_item(make_item(8'hFF, 1'b0, 1'b0));
    queue_item(make_item(8'hA5, 1'b0, 1'b1));
    queue_item(make_item(8'h61, 1'b1, 1'b0));
    queue_item(make_item(8'h62, 1'b1, 1'b0));
    queue_item(make_item(8'h63, 1'b1, 1'b1));
    queue_item(make_item(8'h00, 1'b0, 1'b0));
    queue_item(make_item(8'h00, 1'b1, 1'b0));
    queue_item(make_item(8'hFF, 1'b0, 1'b1));
    queue_item(make_item(8'hFF, 1'b1, 1'b0));
    queue_item(make_item(8'h80, 1'b1, 1'b0));
    queue_item(make_item(8'h55, 1'b0, 1'b0));
    queue_item(make_item(8'h7F, 1'b1, 1'b1));
    queue_item(make_item(8'h00, 1'b0, 1'b1));
    queue_item(make_item(8'hFF, 1'b1, 1'b1));

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_plan[ph];
      recv_stall_pct = stall_plan[ph];
      phase_start    = items_queued;
      queue_message(edge_len[ph]);
      while (items_queued - phase_start < 20) queue_message($urandom_range(0, 12));
      // hold off until every digest word of the phase has come out
      wait_for_drain();
    end

    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* files.f */
src/sha1_pkg.sv
src/sha1_message_digest.sv
src/sha1_md_checker.sv
tb/sha1_message_digest_test.sv
